### hdl/tdva_pkg.sv
// Shared types, widths and the decay rate ladder for the time decay value adjust block.
`timescale 1ns / 1ps

package tdva_pkg;

   localparam int AMT_W    = 54;
   localparam int DIST_W   = 31;
   localparam int WORD_W   = 32;
   localparam int PROD_W   = 2 * WORD_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int LADDER_LEN = 26;
   localparam int IDX_W    = $clog2(LADDER_LEN);
   localparam int MHI_W    = AMT_W - WORD_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LP1,
      ST_LP2,
      ST_LP3,
      ST_LP4,
      ST_FP1,
      ST_FP2,
      ST_FP3,
      ST_FP4,
      ST_FP5
   } state_type;

   // Rate for a distance of 2^i as a 0.64 fraction: high word then low word.
   localparam logic [PROD_W-1:0] LADDER [LADDER_LEN] = '{
      64'hfffff000_00000000,
      64'hffffe000_01000000,
      64'hffffc000_05ffffc0,
      64'hffff8000_1bfffc80,
      64'hffff0000_77ffdd00,
      64'hfffe0001_effeca00,
      64'hfffc0007_dff5d409,
      64'hfff8001f_bfaca8a2,
      64'hfff0007f_7d5d5a6a,
      64'hffe001fe_eacb48a8,
      64'hffc007fd_55dfda2a,
      64'hff801ff6_ad5499cd,
      64'hff007fcd_67f98aad,
      64'hfe01fe9b_74f0943e,
      64'hfc07f540_767d2a82,
      64'hf81fab16_3dc15990,
      64'hf07d5f65_f9604ac9,
      64'he1eb5045_80b6ebf7,
      64'hc75f7b66_a5075def,
      64'h9b459576_663bbb3e,
      64'h5e2d55e7_48e27ab4,
      64'h22a5531d_29a95916,
      64'h04b054d7_fda49c4d,
      64'h0015fc1b_85085be9,
      64'h000001e3_54ca043c,
      64'h00000000_00039089
   };

endpackage

### hdl/tdva_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
`timescale 1ns / 1ps

module tdva_mul (
   input  logic                           clock,
   input  logic [tdva_pkg::WORD_W-1:0]    op_a,
   input  logic [tdva_pkg::WORD_W-1:0]    op_b,
   output logic [tdva_pkg::PROD_W-1:0]    prod
);
   import tdva_pkg::*;

   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
   end

   assign prod = prod_ff;

endmodule

### hdl/time_decay_value_adjust.sv
// Top level: sequencer and accumulator around one shared multiplier for value decay.
`timescale 1ns / 1ps

// Scales a signed 54-bit amount by (1 - 2^-20)^distance. A word is taken when
// start is high and busy is low; busy stays high until the result is out. The
// result appears on rsp_amount_out for exactly one cycle with rsp_valid high,
// and the receiver cannot stall it, so capture it when it comes. A distance of
// zero or of 2^26 and more finishes at once: the strobe comes in the cycle after
// the accept. Otherwise the sequencer walks all 26 ladder bits, one per cycle
// while in ST_SCAN; for each set bit after the lowest one it leaves the scan for
// ST_LP1 to ST_LP4 on the shared 32x32 multiplier, and it ends with ST_FP1 to
// ST_FP5 on the final rate-times-magnitude product, after which the strobe
// comes. A new word can be started in the cycle the strobe is shown.
module time_decay_value_adjust (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [tdva_pkg::AMT_W-1:0]   req_amount_in,
   input  logic        [tdva_pkg::DIST_W-1:0]  req_block_distance,
   output logic                                rsp_valid,
   output logic signed [tdva_pkg::AMT_W-1:0]   rsp_amount_out
);
   import tdva_pkg::*;

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    started_ff, started_in;
   logic [LADDER_LEN-1:0]   dist_ff, dist_in;
   logic [AMT_W-1:0]        mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic [WORD_W-1:0]       rhi_ff, rhi_in;
   logic [WORD_W-1:0]       rlo_ff, rlo_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [AMT_W-1:0]        out_ff, out_in;
   logic                    valid_ff, valid_in;

   logic [WORD_W-1:0]       op_a, op_b;
   logic [PROD_W-1:0]       prod;
   logic [ACC_W-1:0]        acc_sum;
   logic [PROD_W-1:0]       entry;
   logic [WORD_W-1:0]       mhi, mlo;
   logic [AMT_W-1:0]        raw, raw_neg, res_mag;
   logic                    last_idx, bit_set;

   tdva_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // The ladder entry and the magnitude halves feed the multiplier operands.
   assign entry    = LADDER[idx_ff];
   assign mhi      = {{(WORD_W - MHI_W){1'b0}}, mag_ff[AMT_W-1:WORD_W]};
   assign mlo      = mag_ff[WORD_W-1:0];
   assign acc_sum  = acc_ff + {{(ACC_W - PROD_W){1'b0}}, prod};
   assign raw      = req_amount_in;
   assign raw_neg  = ~raw + {{(AMT_W - 1){1'b0}}, 1'b1};
   assign res_mag  = acc_sum[AMT_W-1:0];
   assign last_idx = (idx_ff == IDX_W'(LADDER_LEN - 1));
   assign bit_set  = dist_ff[idx_ff];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if ((req_block_distance == '0) ||
                   (req_block_distance[DIST_W-1:LADDER_LEN] != '0)) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (bit_set && started_ff) begin
               state_in = ST_LP1;
            end else if (last_idx) begin
               state_in = ST_FP1;
            end
         end
         ST_LP1: state_in = ST_LP2;
         ST_LP2: state_in = ST_LP3;
         ST_LP3: state_in = ST_LP4;
         ST_LP4: state_in = last_idx ? ST_FP1 : ST_SCAN;
         ST_FP1: state_in = ST_FP2;
         ST_FP2: state_in = ST_FP3;
         ST_FP3: state_in = ST_FP4;
         ST_FP4: state_in = ST_FP5;
         ST_FP5: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and multiplier operand selection.
   always_comb begin
      idx_in     = idx_ff;
      started_in = started_ff;
      dist_in    = dist_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      rhi_in     = rhi_ff;
      rlo_in     = rlo_ff;
      acc_in     = acc_ff;
      out_in     = out_ff;
      valid_in   = 1'b0;
      op_a       = rhi_ff;
      op_b       = mlo;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in     = '0;
               started_in = 1'b0;
               dist_in    = req_block_distance[LADDER_LEN-1:0];
               neg_in     = raw[AMT_W-1];
               mag_in     = raw[AMT_W-1] ? raw_neg : raw;
               if (req_block_distance == '0) begin
                  out_in   = raw;
                  valid_in = 1'b1;
               end else if (req_block_distance[DIST_W-1:LADDER_LEN] != '0) begin
                  out_in   = '0;
                  valid_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (bit_set && !started_ff) begin
               // Lowest set bit: copy the entry as the starting rate.
               started_in = 1'b1;
               rhi_in     = entry[PROD_W-1:WORD_W];
               rlo_in     = entry[WORD_W-1:0];
            end
            if (!(bit_set && started_ff) && !last_idx) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_LP1: begin
            op_a = entry[WORD_W-1:0];
            op_b = rhi_ff;
         end
         ST_LP2: begin
            acc_in = {{(ACC_W - PROD_W){1'b0}}, prod};
            op_a   = entry[PROD_W-1:WORD_W];
            op_b   = rlo_ff;
         end
         ST_LP3: begin
            acc_in = acc_sum >> WORD_W;
            op_a   = entry[PROD_W-1:WORD_W];
            op_b   = rhi_ff;
         end
         ST_LP4: begin
            rlo_in = acc_sum[WORD_W-1:0];
            rhi_in = acc_sum[PROD_W-1:WORD_W];
            if (!last_idx) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_FP1: begin
            op_a = rlo_ff;
            op_b = mlo;
         end
         ST_FP2: begin
            acc_in = {{(ACC_W - WORD_W){1'b0}}, prod[PROD_W-1:WORD_W]};
            op_a   = rlo_ff;
            op_b   = mhi;
         end
         ST_FP3: begin
            acc_in = acc_sum;
            op_a   = rhi_ff;
            op_b   = mlo;
         end
         ST_FP4: begin
            acc_in = acc_sum >> WORD_W;
            op_a   = rhi_ff;
            op_b   = mhi;
         end
         ST_FP5: begin
            // Put the sign back on the scaled magnitude.
            out_in   = neg_ff ? (~res_mag + {{(AMT_W - 1){1'b0}}, 1'b1}) : res_mag;
            valid_in = 1'b1;
         end
         default: begin
            valid_in = 1'b0;
         end
      endcase
   end

   // Control state resets; payload holds.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= 1'b0;
         started_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         started_ff <= started_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      rhi_ff  <= rhi_in;
      rlo_ff  <= rlo_in;
      acc_ff  <= acc_in;
      out_ff  <= out_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = valid_ff;
   assign rsp_amount_out = out_ff;

endmodule
